// File: rtl/tpae_pkg.sv
// Shared constants, register codes and controller/datapath interface types
// for the tensor permute address engine. No dependencies.
package tpae_pkg;

  localparam int MAX_RANK       = 4;
  localparam int EXTENT_BITS    = 16;
  localparam int DATA_BITS      = 64;
  localparam int INDEX_BITS     = 64;
  localparam int RANK_BITS      = 3;
  localparam int AXIS_BITS      = 2;
  localparam int PERM_BITS      = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int STRIDE_BITS    = EXTENT_BITS * (MAX_RANK - 1);
  localparam int MUL_BITS       = INDEX_BITS + EXTENT_BITS;

  typedef logic [EXTENT_BITS-1:0] ext_t;
  typedef logic [INDEX_BITS-1:0]  idx_t;
  typedef logic [STRIDE_BITS-1:0] ostride_t;
  typedef logic [AXIS_BITS-1:0]   axis_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RANK     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENT_0 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENT_1 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENT_2 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENT_3 = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PERM     = 3'd5;

  localparam logic [RANK_BITS-1:0] RANK_RESET = 3'd4;
  localparam logic [PERM_BITS-1:0] PERM_RESET = 8'd228;

  typedef struct packed {
    logic  init;
    logic  os_step;
    logic  ds_step;
    logic  wrap_step;
    logic  delta_step;
    logic  run;
    axis_t axis;
  } cmd_t;

  typedef struct packed {
    logic restart;
  } sts_t;

endpackage

// File: rtl/tpae_ctrl.sv
// Setup sequencer for the permute engine: walks stride, destination stride
// and step-delta phases after reset or any register write. Uses tpae_pkg.
module tpae_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tpae_pkg::sts_t sts_i,
  output tpae_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_OS,
    ST_DS,
    ST_WRAP,
    ST_DELTA,
    ST_RUN
  } state_e;

  state_e              state_q;
  tpae_pkg::axis_t     axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      axis_q  <= '0;
    end else if (sts_i.restart) begin
      state_q <= ST_INIT;
      axis_q  <= '0;
    end else begin
      unique case (state_q)
        ST_INIT: begin
          state_q <= ST_OS;
          axis_q  <= tpae_pkg::AXIS_BITS'(tpae_pkg::MAX_RANK - 2);
        end
        ST_OS: begin
          if (axis_q == '0) begin
            state_q <= ST_DS;
          end else begin
            axis_q <= axis_q - 1'b1;
          end
        end
        ST_DS: begin
          if (axis_q == tpae_pkg::AXIS_BITS'(tpae_pkg::MAX_RANK - 1)) begin
            state_q <= ST_WRAP;
          end else begin
            axis_q <= axis_q + 1'b1;
          end
        end
        ST_WRAP: begin
          state_q <= ST_DELTA;
        end
        ST_DELTA: begin
          if (axis_q == '0) begin
            state_q <= ST_RUN;
          end else begin
            state_q <= ST_WRAP;
            axis_q  <= axis_q - 1'b1;
          end
        end
        ST_RUN: begin
          state_q <= ST_RUN;
        end
        default: begin
          state_q <= ST_INIT;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.axis       = axis_q;
    cmd_o.init       = (state_q == ST_INIT);
    cmd_o.os_step    = (state_q == ST_OS);
    cmd_o.ds_step    = (state_q == ST_DS);
    cmd_o.wrap_step  = (state_q == ST_WRAP);
    cmd_o.delta_step = (state_q == ST_DELTA);
    cmd_o.run        = (state_q == ST_RUN);
  end

endmodule

// File: rtl/tpae_dp.sv
// Datapath of the permute engine: config registers, stride setup with one
// shared multiplier, coordinate counter, index adder, output register.
// Uses tpae_pkg; driven by tpae_ctrl commands.
module tpae_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tpae_pkg::cmd_t                        cmd_i,
  output tpae_pkg::sts_t                        sts_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tpae_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [tpae_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [tpae_pkg::DATA_BITS-1:0]        value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [tpae_pkg::INDEX_BITS-1:0]       dest_index_o,
  output logic [tpae_pkg::DATA_BITS-1:0]        out_value_o,
  output logic                                  last_o
);

  localparam int NR = tpae_pkg::MAX_RANK;

  logic [tpae_pkg::RANK_BITS-1:0] rank_q;
  tpae_pkg::ext_t                 ext_q [NR];
  logic [tpae_pkg::PERM_BITS-1:0] perm_q;

  tpae_pkg::ostride_t os_q    [NR];
  tpae_pkg::idx_t     ds_q    [NR];
  tpae_pkg::idx_t     delta_q [NR];
  tpae_pkg::idx_t     wrap_q;
  tpae_pkg::idx_t     acc_q;

  tpae_pkg::ext_t     coord_q [NR];
  tpae_pkg::ext_t     coord_d [NR];
  tpae_pkg::idx_t     run_idx_q;
  tpae_pkg::idx_t     run_idx_d;

  logic                             out_valid_q;
  tpae_pkg::idx_t                   dest_index_q;
  logic [tpae_pkg::DATA_BITS-1:0]   out_value_q;
  logic                             last_q;

  logic [tpae_pkg::RANK_BITS-1:0] rank_used;
  tpae_pkg::ext_t                 ext_eff [NR];
  tpae_pkg::ext_t                 out_ext [NR];
  logic [NR-1:0]                  full;
  tpae_pkg::axis_t                sel;
  logic                           carry;

  tpae_pkg::axis_t                axis_nx;
  tpae_pkg::axis_t                perm_k;
  tpae_pkg::idx_t                 mul_a;
  tpae_pkg::ext_t                 mul_b;
  logic [tpae_pkg::MUL_BITS-1:0]  mul_full;
  tpae_pkg::idx_t                 mul_res;

  logic cfg_we;
  logic in_fire;

  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i & cfg_ready_o;
  assign sts_o.restart = cfg_we;

  assign in_ready_o  = cmd_i.run & (~out_valid_q | out_ready_i);
  assign in_fire     = in_valid_i & in_ready_o;

  assign out_valid_o  = out_valid_q;
  assign dest_index_o = dest_index_q;
  assign out_value_o  = out_value_q;
  assign last_o       = last_q;

  // Effective extents: zero and out-of-rank axes count as one.
  assign rank_used = (rank_q > tpae_pkg::RANK_BITS'(NR)) ? tpae_pkg::RANK_BITS'(NR) : rank_q;

  always_comb begin
    for (int a = 0; a < NR; a++) begin
      ext_eff[a] = ((tpae_pkg::RANK_BITS'(a) < rank_used) && (ext_q[a] != '0)) ?
                   ext_q[a] : tpae_pkg::EXTENT_BITS'(1);
    end
    for (int k = 0; k < NR; k++) begin
      out_ext[k] = (tpae_pkg::RANK_BITS'(k) < rank_used) ?
                   ext_eff[perm_q[2*k +: tpae_pkg::AXIS_BITS]] : tpae_pkg::EXTENT_BITS'(1);
    end
  end

  // Shared multiplier: output strides, then per-axis wrap amounts.
  assign axis_nx = tpae_pkg::AXIS_BITS'(cmd_i.axis + 1'b1);
  assign perm_k  = perm_q[{cmd_i.axis, 1'b0} +: tpae_pkg::AXIS_BITS];

  always_comb begin
    if (cmd_i.os_step) begin
      mul_a = tpae_pkg::INDEX_BITS'(os_q[axis_nx]);
      mul_b = out_ext[axis_nx];
    end else begin
      mul_a = ds_q[cmd_i.axis];
      mul_b = ext_eff[cmd_i.axis] - 1'b1;
    end
  end

  assign mul_full = tpae_pkg::MUL_BITS'(mul_a) * tpae_pkg::MUL_BITS'(mul_b);
  assign mul_res  = mul_full[tpae_pkg::INDEX_BITS-1:0];

  // Innermost axis that does not wrap; all inner ones wrap to zero.
  always_comb begin
    sel   = '0;
    carry = 1'b1;
    for (int a = 0; a < NR; a++) begin
      full[a] = ({1'b0, coord_q[a]} + 1'b1) >= {1'b0, ext_eff[a]};
      if (!full[a]) begin
        sel   = tpae_pkg::AXIS_BITS'(a);
        carry = 1'b0;
      end
    end
    for (int a = 0; a < NR; a++) begin
      if (carry || (tpae_pkg::AXIS_BITS'(a) > sel)) begin
        coord_d[a] = '0;
      end else if (tpae_pkg::AXIS_BITS'(a) == sel) begin
        coord_d[a] = coord_q[a] + 1'b1;
      end else begin
        coord_d[a] = coord_q[a];
      end
    end
    run_idx_d = carry ? '0 : run_idx_q + delta_q[sel];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= tpae_pkg::RANK_RESET;
      perm_q <= tpae_pkg::PERM_RESET;
      for (int a = 0; a < NR; a++) begin
        ext_q[a] <= tpae_pkg::EXTENT_BITS'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        tpae_pkg::REG_RANK:     rank_q   <= cfg_data_i[tpae_pkg::RANK_BITS-1:0];
        tpae_pkg::REG_EXTENT_0: ext_q[0] <= cfg_data_i;
        tpae_pkg::REG_EXTENT_1: ext_q[1] <= cfg_data_i;
        tpae_pkg::REG_EXTENT_2: ext_q[2] <= cfg_data_i;
        tpae_pkg::REG_EXTENT_3: ext_q[3] <= cfg_data_i;
        tpae_pkg::REG_PERM:     perm_q   <= cfg_data_i[tpae_pkg::PERM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stride setup registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      os_q[NR-1] <= tpae_pkg::STRIDE_BITS'(1);
      acc_q      <= '0;
      for (int a = 0; a < NR; a++) begin
        ds_q[a] <= '0;
      end
    end
    if (cmd_i.os_step) begin
      os_q[cmd_i.axis] <= mul_res[tpae_pkg::STRIDE_BITS-1:0];
    end
    if (cmd_i.ds_step && ({1'b0, cmd_i.axis} < rank_used) && ({1'b0, perm_k} < rank_used)) begin
      ds_q[perm_k] <= ds_q[perm_k] + tpae_pkg::INDEX_BITS'(os_q[cmd_i.axis]);
    end
    if (cmd_i.wrap_step) begin
      wrap_q <= mul_res;
    end
    if (cmd_i.delta_step) begin
      delta_q[cmd_i.axis] <= ds_q[cmd_i.axis] - acc_q;
      acc_q               <= acc_q + wrap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_idx_q <= '0;
      for (int a = 0; a < NR; a++) begin
        coord_q[a] <= '0;
      end
    end else if (cmd_i.init) begin
      run_idx_q <= '0;
      for (int a = 0; a < NR; a++) begin
        coord_q[a] <= '0;
      end
    end else if (in_fire) begin
      run_idx_q <= run_idx_d;
      for (int a = 0; a < NR; a++) begin
        coord_q[a] <= coord_d[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dest_index_q <= run_idx_q;
      out_value_q  <= value_i;
      last_q       <= carry;
    end
  end

endmodule

// File: rtl/tensor_permute_address_engine.sv
// Top level of the 4-D tensor permute address engine.
// Instantiates tpae_ctrl and tpae_dp; uses tpae_pkg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready     | value
//   out     | out       | out_valid/out_ready   | dest_index, out_value, last
//
// After reset or any cfg beat, a setup sequence computes the strides
// (one shared multiplier, one axis at a time); in_ready is low then.
// Afterwards one beat per cycle while out is not stalled: each step is one
// 64-bit add of a precomputed per-axis delta to the running index.
// A stalled out channel holds the output register and drops in_ready.
module tensor_permute_address_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tpae_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [tpae_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tpae_pkg::DATA_BITS-1:0]      value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tpae_pkg::INDEX_BITS-1:0]     dest_index_o,
  output logic [tpae_pkg::DATA_BITS-1:0]      out_value_o,
  output logic                                last_o
);

  tpae_pkg::cmd_t cmd;
  tpae_pkg::sts_t sts;

  tpae_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tpae_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dest_index_o (dest_index_o),
    .out_value_o  (out_value_o),
    .last_o       (last_o)
  );

endmodule

// File: rtl/tpae_chk.sv
// Port-level checker for tensor_permute_address_engine, bound to the top.
// Uses tpae_pkg for widths.
module tpae_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [tpae_pkg::DATA_BITS-1:0]      value_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [tpae_pkg::INDEX_BITS-1:0]     dest_index_o,
  input logic [tpae_pkg::DATA_BITS-1:0]      out_value_o,
  input logic                                last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dest_index_o) &&
    $stable(out_value_o) && $stable(last_o))
    else $error("out beat changed while stalled");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o && (out_value_o == $past(value_i)))
    else $error("accepted beat not presented with its value");

  a_cfg_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("input taken during stride setup");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while output register full");

endmodule

bind tensor_permute_address_engine tpae_chk u_tpae_chk (.*);
